>>> hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared widths, field layout and pass codes for the critical path core.
// ----------------------------------------------------------------------------
package cpa_pkg;

    // Fixed field widths
    localparam int VTX_W     = 5;   // zero-based vertex on the input side
    localparam int DUR_W     = 16;  // activity duration field
    localparam int VC_W      = 6;   // vertex_count register
    localparam int OUT_VTX_W = 6;   // one-based vertex on the result side

    localparam logic [VC_W-1:0] VC_RESET = 6'd9;
    localparam logic [VC_W-1:0] VC_MIN   = 6'd2;

    // Stream widths
    localparam int S_TDATA_W = 32;  // tail, head, duration, zero pad
    localparam int M_TDATA_W = 16;  // from, to, zero pad
    localparam int M_TUSER_W = 2;   // is_edge, overflow

    // Which sweep of the network the sequencer is in
    typedef enum logic [1:0] {
        PASS_FWD,
        PASS_BWD,
        PASS_EMIT
    } pass_t;

endpackage

>>> hdl/critical_path_aoe_core.sv
// ----------------------------------------------------------------------------
// critical_path_aoe_core
// Critical path method over an activity-on-edge network loaded edge by edge.
//
// Each request on the s_ side carries one edge (tail, head, duration); the
// edge is stored in an edge memory and pushed on the front of its tail
// vertex's list, so every list runs newest edge first. Loading takes one
// request per cycle. An edge with a vertex at or above vertex_count is
// dropped quietly; an edge that arrives when the table is full is dropped
// and raises the overflow flag. The request with tlast set starts the run:
// a forward pass (earliest times), a backward pass seeded with the sink's
// earliest time (vertex 0 included), then an emit pass that walks the lists
// again in ascending tail order and sends every edge whose earliest start
// equals its latest start, one-based, with tlast on the final one. When no
// edge is critical a single request with is_edge low and zero vertices is
// sent. Afterwards the lists, edge count and overflow flag are cleared and
// the core takes new edges, even while the last result still waits on m_.
// Run time is set by the time memory and the edge memory, each with a
// registered read, walked by one sequencer; it grows with the vertex
// count, the stored edges and the critical edges, and any stall on
// m_tready adds to it. An edge with an out-of-range head skips the time
// read. vertex_count is written with cfg_we; the user must write it only
// while the core is idle, as the core itself does not enforce this. It is
// clamped to the range 2 .. min(MAX_VERTICES, 32).
// ----------------------------------------------------------------------------
module critical_path_aoe_core #(
    parameter int MAX_VERTICES = 32,   // 2 .. 1024, vertex slots = min(this, 32)
    parameter int MAX_EDGES    = 64,   // 1 .. 64, edge memory depth
    parameter int WEIGHT_BITS  = 16    // 4 .. 32, stored duration bits
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // vertex_count register
    input  logic                            cfg_we,
    input  logic [cpa_pkg::VC_W-1:0]        cfg_wdata,

    // edge requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cpa_pkg::S_TDATA_W-1:0]   s_tdata,   // tail[4:0], head[9:5],
                                                       // duration[25:10], pad
    input  logic                            s_tlast,   // last_edge

    // critical edge results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cpa_pkg::M_TDATA_W-1:0]   m_tdata,   // from_vertex[5:0],
                                                       // to_vertex[11:6], pad
    output logic [cpa_pkg::M_TUSER_W-1:0]   m_tuser,   // is_edge[0], overflow[1]
    output logic                            m_tlast    // last_result
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int V_SLOTS = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int VIDX_W  = $clog2(V_SLOTS);
    localparam int EIDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int LINK_W  = EIDX_W + 1;               // msb set = end of list
    localparam int CNT_W   = $clog2(MAX_EDGES + 1);
    // Event times never exceed the sum of all weights; latest times never
    // drop below minus that sum. One more bit for the sign.
    localparam int TIME_W  = WEIGHT_BITS + $clog2(MAX_EDGES + 1) + 1;
    localparam int TADDR_W = VIDX_W + 1;               // {latest select, vertex}
    localparam int TDEPTH  = 2 * (2 ** VIDX_W);
    localparam int PAD_W   = cpa_pkg::M_TDATA_W - 2 * cpa_pkg::OUT_VTX_W;

    localparam logic [LINK_W-1:0]        LINK_NULL = LINK_W'(1) << EIDX_W;
    localparam logic [cpa_pkg::VC_W-1:0] VC_LIM    = cpa_pkg::VC_W'(V_SLOTS);
    localparam logic [CNT_W-1:0]         CNT_FULL  = CNT_W'(MAX_EDGES);

    typedef struct packed {
        logic [VIDX_W-1:0]      target;
        logic [WEIGHT_BITS-1:0] weight;
        logic [LINK_W-1:0]      next;
    } edge_t;

    typedef enum logic [3:0] {
        ST_IDLE,     // take edge requests
        ST_VSTART,   // read time of vertex i, fetch its list head
        ST_VLOAD,    // latch vertex time, read first edge
        ST_EREAD,    // edge word back, read time of its head
        ST_TREAD,    // head time back, relax / compare
        ST_ENEXT,    // follow the list link
        ST_VEND,     // close vertex, step i, change pass or finish
        ST_PUSH,     // hand a critical edge to the hold slot
        ST_FINAL     // send last result, clear lists
    } state_t;

    // ------------------------------------------------------------------
    // Input field split
    // ------------------------------------------------------------------
    logic [cpa_pkg::VTX_W-1:0] tail_in;
    logic [cpa_pkg::VTX_W-1:0] head_in;
    logic [cpa_pkg::DUR_W-1:0] dur_in;

    assign tail_in = s_tdata[cpa_pkg::VTX_W-1:0];
    assign head_in = s_tdata[2*cpa_pkg::VTX_W-1:cpa_pkg::VTX_W];
    assign dur_in  = s_tdata[2*cpa_pkg::VTX_W+cpa_pkg::DUR_W-1:2*cpa_pkg::VTX_W];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    cpa_pkg::pass_t             pass_reg, pass_next;
    logic [cpa_pkg::VC_W-1:0]   vc_reg, vc_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       ovf_reg, ovf_next;
    logic [LINK_W-1:0]          first_reg [V_SLOTS];
    logic [LINK_W-1:0]          first_next [V_SLOTS];
    logic [V_SLOTS-1:0]         fv_reg, fv_next;      // list head valid
    logic [V_SLOTS-1:0]         ev_reg, ev_next;      // earliest time written
    logic [V_SLOTS-1:0]         lv_reg, lv_next;      // latest time written

    logic [VIDX_W-1:0]          i_reg, i_next;
    logic [LINK_W-1:0]          p_reg, p_next;
    logic [VIDX_W-1:0]          k_reg, k_next;
    logic [WEIGHT_BITS-1:0]     w_reg, w_next;
    logic signed [TIME_W-1:0]   ei_reg, ei_next;      // earliest time of i
    logic signed [TIME_W-1:0]   li_reg, li_next;      // running latest of i
    logic signed [TIME_W-1:0]   sink_reg, sink_next;  // sink earliest time

    logic [VIDX_W-1:0]          cand_i_reg, cand_i_next;
    logic [VIDX_W-1:0]          cand_k_reg, cand_k_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [VIDX_W-1:0]          pend_i_reg, pend_i_next;
    logic [VIDX_W-1:0]          pend_k_reg, pend_k_next;

    logic                               m_valid_reg, m_valid_next;
    logic [cpa_pkg::OUT_VTX_W-1:0]      m_from_reg, m_from_next;
    logic [cpa_pkg::OUT_VTX_W-1:0]      m_to_reg, m_to_next;
    logic                               m_edge_reg, m_edge_next;
    logic                               m_ovf_reg, m_ovf_next;
    logic                               m_last_reg, m_last_next;

    // ------------------------------------------------------------------
    // Memories: edge table and vertex times
    // ------------------------------------------------------------------
    edge_t                      edge_mem [MAX_EDGES];
    edge_t                      edge_rd_reg;
    logic                       edge_we, edge_re;
    logic [EIDX_W-1:0]          edge_waddr, edge_raddr;
    edge_t                      edge_wdata;

    logic signed [TIME_W-1:0]   time_mem [TDEPTH];
    logic signed [TIME_W-1:0]   time_rd_reg;
    logic                       time_we, time_re;
    logic [TADDR_W-1:0]         time_waddr, time_raddr;
    logic signed [TIME_W-1:0]   time_wdata;

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        if (edge_re) begin
            edge_rd_reg <= edge_mem[edge_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (time_we) begin
            time_mem[time_waddr] <= time_wdata;
        end
        if (time_re) begin
            time_rd_reg <= time_mem[time_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [cpa_pkg::VC_W-1:0]   n_eff;
    logic                       in_accept;
    logic                       in_range;
    logic                       out_free;
    logic                       i_is_sink;
    logic                       head_out;         // stored head no longer below n
    logic                       k_is_i;
    logic signed [TIME_W-1:0]   w_ext;
    logic signed [TIME_W-1:0]   tk;               // time of head vertex k
    logic signed [TIME_W-1:0]   fwd_sum;
    logic signed [TIME_W-1:0]   bwd_diff;

    // clamp vertex_count to 2 .. slot count
    assign n_eff = (vc_reg < cpa_pkg::VC_MIN) ? cpa_pkg::VC_MIN :
                   (vc_reg > VC_LIM)          ? VC_LIM : vc_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_range  = (cpa_pkg::VC_W'(tail_in) < n_eff) &&
                       (cpa_pkg::VC_W'(head_in) < n_eff);
    assign out_free  = !m_valid_reg || m_tready;
    assign i_is_sink = (cpa_pkg::VC_W'(i_reg) == (n_eff - cpa_pkg::VC_W'(1)));
    assign head_out  = (cpa_pkg::VC_W'(edge_rd_reg.target) >= n_eff);
    assign k_is_i    = (k_reg == i_reg);
    assign w_ext     = TIME_W'(w_reg);
    assign fwd_sum   = ei_reg + w_ext;
    assign bwd_diff  = tk - w_ext;

    // Head time: unwritten earliest reads 0, unwritten latest reads the sink
    // time. In the forward and backward passes a self loop sees the running value of its own vertex.
    always_comb begin
        case (pass_reg)
            cpa_pkg::PASS_FWD: begin
                if (k_is_i)
                    tk = ei_reg;
                else if (ev_reg[k_reg])
                    tk = time_rd_reg;
                else
                    tk = '0;
            end
            cpa_pkg::PASS_BWD: begin
                if (k_is_i)
                    tk = li_reg;
                else if (lv_reg[k_reg])
                    tk = time_rd_reg;
                else
                    tk = sink_reg;
            end
            default: begin
                tk = lv_reg[k_reg] ? time_rd_reg : sink_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        vc_next         = cfg_we ? cfg_wdata : vc_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        first_next      = first_reg;
        fv_next         = fv_reg;
        ev_next         = ev_reg;
        lv_next         = lv_reg;
        i_next          = i_reg;
        p_next          = p_reg;
        k_next          = k_reg;
        w_next          = w_reg;
        ei_next         = ei_reg;
        li_next         = li_reg;
        sink_next       = sink_reg;
        cand_i_next     = cand_i_reg;
        cand_k_next     = cand_k_reg;
        pend_valid_next = pend_valid_reg;
        pend_i_next     = pend_i_reg;
        pend_k_next     = pend_k_reg;

        m_valid_next    = m_valid_reg && !m_tready;
        m_from_next     = m_from_reg;
        m_to_next       = m_to_reg;
        m_edge_next     = m_edge_reg;
        m_ovf_next      = m_ovf_reg;
        m_last_next     = m_last_reg;

        edge_we    = 1'b0;
        edge_waddr = '0;
        edge_wdata = '0;
        edge_re    = 1'b0;
        edge_raddr = '0;
        time_we    = 1'b0;
        time_waddr = '0;
        time_wdata = '0;
        time_re    = 1'b0;
        time_raddr = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_range) begin
                        if (cnt_reg != CNT_FULL) begin
                            // push on front of the tail's list
                            edge_we           = 1'b1;
                            edge_waddr        = cnt_reg[EIDX_W-1:0];
                            edge_wdata.target = head_in[VIDX_W-1:0];
                            edge_wdata.weight = WEIGHT_BITS'(dur_in);
                            edge_wdata.next   = fv_reg[tail_in[VIDX_W-1:0]] ?
                                                first_reg[tail_in[VIDX_W-1:0]] :
                                                LINK_NULL;
                            first_next[tail_in[VIDX_W-1:0]] =
                                {1'b0, cnt_reg[EIDX_W-1:0]};
                            fv_next[tail_in[VIDX_W-1:0]] = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        ev_next    = '0;
                        lv_next    = '0;
                        pass_next  = cpa_pkg::PASS_FWD;
                        i_next     = '0;
                        state_next = ST_VSTART;
                    end
                end
            end

            ST_VSTART: begin
                time_re    = 1'b1;
                time_raddr = {1'b0, i_reg};
                p_next     = fv_reg[i_reg] ? first_reg[i_reg] : LINK_NULL;
                state_next = ST_VLOAD;
            end

            ST_VLOAD: begin
                ei_next = ev_reg[i_reg] ? time_rd_reg : '0;
                li_next = sink_reg;
                if (p_reg[LINK_W-1]) begin
                    state_next = ST_VEND;
                end else begin
                    edge_re    = 1'b1;
                    edge_raddr = p_reg[EIDX_W-1:0];
                    state_next = ST_EREAD;
                end
            end

            ST_EREAD: begin
                k_next = edge_rd_reg.target;
                w_next = edge_rd_reg.weight;
                p_next = edge_rd_reg.next;
                if (head_out) begin
                    state_next = ST_ENEXT;
                end else begin
                    time_re    = 1'b1;
                    time_raddr = {(pass_reg != cpa_pkg::PASS_FWD), edge_rd_reg.target};
                    state_next = ST_TREAD;
                end
            end

            ST_TREAD: begin
                state_next = ST_ENEXT;
                case (pass_reg)
                    cpa_pkg::PASS_FWD: begin
                        if (fwd_sum > tk) begin
                            time_we    = 1'b1;
                            time_waddr = {1'b0, k_reg};
                            time_wdata = fwd_sum;
                            ev_next[k_reg] = 1'b1;
                            if (k_is_i) begin
                                ei_next = fwd_sum;
                            end
                        end
                    end
                    cpa_pkg::PASS_BWD: begin
                        if (bwd_diff < li_reg) begin
                            li_next = bwd_diff;
                        end
                    end
                    default: begin
                        if (ei_reg == bwd_diff) begin
                            cand_i_next = i_reg;
                            cand_k_next = k_reg;
                            state_next  = ST_PUSH;
                        end
                    end
                endcase
            end

            ST_ENEXT: begin
                if (p_reg[LINK_W-1]) begin
                    state_next = ST_VEND;
                end else begin
                    edge_re    = 1'b1;
                    edge_raddr = p_reg[EIDX_W-1:0];
                    state_next = ST_EREAD;
                end
            end

            ST_VEND: begin
                state_next = ST_VSTART;
                case (pass_reg)
                    cpa_pkg::PASS_FWD: begin
                        if (i_is_sink) begin
                            sink_next = ei_reg;
                            pass_next = cpa_pkg::PASS_BWD;
                            i_next    = VIDX_W'(n_eff - cpa_pkg::VC_W'(2));
                        end else begin
                            i_next = i_reg + VIDX_W'(1);
                        end
                    end
                    cpa_pkg::PASS_BWD: begin
                        time_we        = 1'b1;
                        time_waddr     = {1'b1, i_reg};
                        time_wdata     = li_reg;
                        lv_next[i_reg] = 1'b1;
                        if (i_reg == '0) begin
                            pass_next = cpa_pkg::PASS_EMIT;
                        end else begin
                            i_next = i_reg - VIDX_W'(1);
                        end
                    end
                    default: begin
                        if (i_is_sink) begin
                            state_next = ST_FINAL;
                        end else begin
                            i_next = i_reg + VIDX_W'(1);
                        end
                    end
                endcase
            end

            // One critical edge is held back so the final one can carry tlast.
            ST_PUSH: begin
                if (!pend_valid_reg) begin
                    pend_valid_next = 1'b1;
                    pend_i_next     = cand_i_reg;
                    pend_k_next     = cand_k_reg;
                    state_next      = ST_ENEXT;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_from_next  = cpa_pkg::OUT_VTX_W'(pend_i_reg) +
                                   cpa_pkg::OUT_VTX_W'(1);
                    m_to_next    = cpa_pkg::OUT_VTX_W'(pend_k_reg) +
                                   cpa_pkg::OUT_VTX_W'(1);
                    m_edge_next  = 1'b1;
                    m_ovf_next   = ovf_reg;
                    m_last_next  = 1'b0;
                    pend_i_next  = cand_i_reg;
                    pend_k_next  = cand_k_reg;
                    state_next   = ST_ENEXT;
                end
            end

            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        m_from_next = cpa_pkg::OUT_VTX_W'(pend_i_reg) +
                                      cpa_pkg::OUT_VTX_W'(1);
                        m_to_next   = cpa_pkg::OUT_VTX_W'(pend_k_reg) +
                                      cpa_pkg::OUT_VTX_W'(1);
                        m_edge_next = 1'b1;
                    end else begin
                        m_from_next = '0;
                        m_to_next   = '0;
                        m_edge_next = 1'b0;
                    end
                    m_ovf_next      = ovf_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    fv_next         = '0;
                    cnt_next        = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        first_reg   <= first_next;
        i_reg       <= i_next;
        p_reg       <= p_next;
        k_reg       <= k_next;
        w_reg       <= w_next;
        ei_reg      <= ei_next;
        li_reg      <= li_next;
        sink_reg    <= sink_next;
        cand_i_reg  <= cand_i_next;
        cand_k_reg  <= cand_k_next;
        pend_i_reg  <= pend_i_next;
        pend_k_reg  <= pend_k_next;
        m_from_reg  <= m_from_next;
        m_to_reg    <= m_to_next;
        m_edge_reg  <= m_edge_next;
        m_ovf_reg   <= m_ovf_next;
        m_last_reg  <= m_last_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pass_reg       <= cpa_pkg::PASS_FWD;
            vc_reg         <= cpa_pkg::VC_RESET;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            fv_reg         <= '0;
            ev_reg         <= '0;
            lv_reg         <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            vc_reg         <= vc_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            fv_reg         <= fv_next;
            ev_reg         <= ev_next;
            lv_reg         <= lv_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_to_reg, m_from_reg};
    assign m_tuser  = {m_ovf_reg, m_edge_reg};
    assign m_tlast  = m_last_reg;

endmodule
